/* design/bounded_array_list_engine_defines.svh */
// assertion macros for the checker file
`ifndef BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ARRAY_LIST_ENGINE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define BALE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define BALE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/bale_pkg.sv */
package bale_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int CMD_W    = 4;
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 64;
  localparam int POS_W    = 5;

  // input tdata layout
  localparam int IN_KEY_LO = 0;
  localparam int IN_PAY_LO = IN_KEY_LO + KEY_W;
  localparam int IN_POS_LO = IN_PAY_LO + PAY_W;
  localparam int IN_DATA_W = ((IN_POS_LO + POS_W + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_KEY_LO   = 0;
  localparam int OUT_PAY_LO   = OUT_KEY_LO + KEY_W;
  localparam int OUT_CNT_LO   = OUT_PAY_LO + PAY_W;
  localparam int OUT_FULL_BIT = OUT_CNT_LO + CNT_W;
  localparam int OUT_EMPTY_BIT = OUT_FULL_BIT + 1;
  localparam int OUT_DATA_W   = ((OUT_EMPTY_BIT + 1 + 7) / 8) * 8;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INS_END   = 4'd0;
  localparam logic [CMD_W-1:0] CMD_INS_START = 4'd1;
  localparam logic [CMD_W-1:0] CMD_INS_SORT  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_RM_SHIFT  = 4'd3;
  localparam logic [CMD_W-1:0] CMD_RM_SWAP   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_RM_FIRST  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_RM_LAST   = 4'd6;
  localparam logic [CMD_W-1:0] CMD_FIND_POS  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_FIND_KEY  = 4'd8;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  function automatic logic key_less(logic signed [KEY_W-1:0] a,
                                    logic signed [KEY_W-1:0] b);
    return a < b;
  endfunction

endpackage

/* design/bale_ram.sv */
module bale_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

/* design/bounded_array_list_engine.sv */
// channel | dir | handshake               | contents
// in_     | in  | in_tvalid / in_tready   | tuser cmd, tdata key, payload, position
// out_    | out | out_tvalid / out_tready | tuser ok, tdata found record, count, flags
//
// one request at a time; in_tready is high only while the sequencer is idle
// one ram port pair moves one entry per cycle; remove last and a bad command go straight
// to the result, while a full key scan or shift walks the stored entries
// the result sits in an output register, so the next request is taken while it waits
// rst_n (synchronous, active low) clears the count and control; entries are not cleared
module bounded_array_list_engine (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [bale_pkg::IN_DATA_W-1:0]   in_tdata,  // key, payload, position, zero pad
  input  logic [bale_pkg::CMD_W-1:0]       in_tuser,  // cmd
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bale_pkg::OUT_DATA_W-1:0]  out_tdata, // found_key, found_payload,
                                                       // entry_count, is_full, is_empty, pad
  output logic                             out_tuser  // ok
);

  localparam int IDX_W = bale_pkg::IDX_W;
  localparam int CNT_W = bale_pkg::CNT_W;
  localparam int KEY_W = bale_pkg::KEY_W;
  localparam int PAY_W = bale_pkg::PAY_W;
  localparam int POS_W = bale_pkg::POS_W;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;  // walk entries looking for a key
  localparam logic [3:0] S_OPEN   = 4'd2;  // start opening a hole at gap
  localparam logic [3:0] S_SHUP   = 4'd3;  // move entries up by one
  localparam logic [3:0] S_PUT    = 4'd4;  // write the new record into the hole
  localparam logic [3:0] S_CLOSE  = 4'd5;  // start closing the hole at gap
  localparam logic [3:0] S_SHDN   = 4'd6;  // move entries down by one
  localparam logic [3:0] S_SWAPRD = 4'd7;  // read the last entry
  localparam logic [3:0] S_SWAPWR = 4'd8;  // write it into the hole
  localparam logic [3:0] S_FETCH  = 4'd9;  // read data for find by position
  localparam logic [3:0] S_DONE   = 4'd10; // hand the result to the output register

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(bale_pkg::CAPACITY);

  logic [3:0]                  state_r, state_nxt;
  logic [bale_pkg::CMD_W-1:0]  cmd_r, cmd_nxt;
  logic signed [KEY_W-1:0]     key_r, key_nxt;
  logic [PAY_W-1:0]            pay_r, pay_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [CNT_W-1:0]            gap_r, gap_nxt;   // hole / hit index
  logic [CNT_W-1:0]            src_r, src_nxt;   // index whose read data is arriving
  logic                        res_ok_r, res_ok_nxt;
  logic signed [KEY_W-1:0]     res_key_r, res_key_nxt;
  logic [PAY_W-1:0]            res_pay_r, res_pay_nxt;

  // output register
  logic                        out_valid_r;
  logic                        out_ok_r;
  logic signed [KEY_W-1:0]     out_key_r;
  logic [PAY_W-1:0]            out_pay_r;
  logic [CNT_W-1:0]            out_cnt_r;
  logic                        out_full_r;
  logic                        out_empty_r;
  logic                        out_load;

  // ram side
  logic                        ram_wr_en;
  logic [IDX_W-1:0]            ram_wr_addr;
  bale_pkg::entry_t            ram_wr_data;
  logic [IDX_W-1:0]            ram_rd_addr;
  bale_pkg::entry_t            rd_ent;

  // request fields
  logic [bale_pkg::CMD_W-1:0]  req_cmd;
  logic signed [KEY_W-1:0]     req_key;
  logic [PAY_W-1:0]            req_pay;
  logic [POS_W-1:0]            req_pos;
  logic [POS_W-1:0]            pos_m1;

  logic [CNT_W-1:0]            cnt_m1, src_p1, src_m1, gap_p1;
  logic                        is_full, is_empty;
  logic                        scan_hit;
  logic                        req_take;

  assign req_cmd = in_tuser;
  assign req_key = in_tdata[bale_pkg::IN_KEY_LO +: KEY_W];
  assign req_pay = in_tdata[bale_pkg::IN_PAY_LO +: PAY_W];
  assign req_pos = in_tdata[bale_pkg::IN_POS_LO +: POS_W];
  assign pos_m1  = req_pos - POS_W'(1);

  assign cnt_m1 = cnt_r - CNT_W'(1);
  assign src_p1 = src_r + CNT_W'(1);
  assign src_m1 = src_r - CNT_W'(1);
  assign gap_p1 = gap_r + CNT_W'(1);

  assign is_full  = (cnt_r == CAP_CNT);
  assign is_empty = (cnt_r == '0);

  assign in_tready = (state_r == S_IDLE);
  assign req_take  = in_tvalid && in_tready;

  // sorted insert stops at the first entry not below the key, removes and
  // finds stop at the first equal key
  assign scan_hit = (cmd_r == bale_pkg::CMD_INS_SORT) ?
                    !bale_pkg::key_less(rd_ent.key, key_r) :
                    (rd_ent.key == key_r);

  // result may move out when the output register is free or being emptied
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  bale_ram #(
    .WIDTH(bale_pkg::ENTRY_W),
    .DEPTH(bale_pkg::CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(rd_ent)
  );

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    pay_nxt     = pay_r;
    cnt_nxt     = cnt_r;
    gap_nxt     = gap_r;
    src_nxt     = src_r;
    res_ok_nxt  = res_ok_r;
    res_key_nxt = res_key_r;
    res_pay_nxt = res_pay_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = gap_r[IDX_W-1:0];
    ram_wr_data = rd_ent;
    ram_rd_addr = '0;

    unique case (state_r)
      S_IDLE: begin
        if (req_take) begin
          cmd_nxt     = req_cmd;
          key_nxt     = req_key;
          pay_nxt     = req_pay;
          res_ok_nxt  = 1'b0;
          res_key_nxt = '0;
          res_pay_nxt = '0;
          src_nxt     = '0;
          state_nxt   = S_DONE;
          unique case (req_cmd) inside
            bale_pkg::CMD_INS_END: begin
              if (!is_full) begin
                gap_nxt   = cnt_r;
                state_nxt = S_OPEN;
              end
            end
            bale_pkg::CMD_INS_START: begin
              if (!is_full) begin
                gap_nxt   = '0;
                state_nxt = S_OPEN;
              end
            end
            bale_pkg::CMD_INS_SORT: begin
              if (!is_full) begin
                if (is_empty) begin
                  gap_nxt   = '0;
                  state_nxt = S_OPEN;
                end else begin
                  state_nxt = S_SCAN;
                end
              end
            end
            bale_pkg::CMD_RM_SHIFT, bale_pkg::CMD_RM_SWAP, bale_pkg::CMD_FIND_KEY: begin
              if (!is_empty) begin
                state_nxt = S_SCAN;
              end
            end
            bale_pkg::CMD_RM_FIRST: begin
              if (!is_empty) begin
                gap_nxt   = '0;
                state_nxt = S_CLOSE;
              end
            end
            bale_pkg::CMD_RM_LAST: begin
              if (!is_empty) begin
                cnt_nxt    = cnt_m1;
                res_ok_nxt = 1'b1;
              end
            end
            bale_pkg::CMD_FIND_POS: begin
              if ((req_pos != '0) && (CNT_W'(req_pos) <= cnt_r)) begin
                ram_rd_addr = pos_m1[IDX_W-1:0];
                state_nxt   = S_FETCH;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_hit) begin
          gap_nxt = src_r;
          unique case (cmd_r)
            bale_pkg::CMD_INS_SORT: state_nxt = S_OPEN;
            bale_pkg::CMD_RM_SHIFT: state_nxt = S_CLOSE;
            bale_pkg::CMD_RM_SWAP:  state_nxt = S_SWAPRD;
            bale_pkg::CMD_FIND_KEY: begin
              res_ok_nxt  = 1'b1;
              res_key_nxt = rd_ent.key;
              res_pay_nxt = rd_ent.payload;
              state_nxt   = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end else if (src_r == cnt_m1) begin
          // no hit: a sorted insert goes at the end, anything else fails
          gap_nxt   = cnt_r;
          state_nxt = (cmd_r == bale_pkg::CMD_INS_SORT) ? S_OPEN : S_DONE;
        end else begin
          ram_rd_addr = src_p1[IDX_W-1:0];
          src_nxt     = src_p1;
        end
      end

      S_OPEN: begin
        if (gap_r == cnt_r) begin
          state_nxt = S_PUT;
        end else begin
          ram_rd_addr = cnt_m1[IDX_W-1:0];
          src_nxt     = cnt_m1;
          state_nxt   = S_SHUP;
        end
      end

      S_SHUP: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = src_p1[IDX_W-1:0];
        if (src_r == gap_r) begin
          state_nxt = S_PUT;
        end else begin
          ram_rd_addr = src_m1[IDX_W-1:0];
          src_nxt     = src_m1;
        end
      end

      S_PUT: begin
        ram_wr_en           = 1'b1;
        ram_wr_data.key     = key_r;
        ram_wr_data.payload = pay_r;
        cnt_nxt             = cnt_r + CNT_W'(1);
        res_ok_nxt          = 1'b1;
        state_nxt           = S_DONE;
      end

      S_CLOSE: begin
        if (gap_p1 >= cnt_r) begin
          cnt_nxt    = cnt_m1;
          res_ok_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          ram_rd_addr = gap_p1[IDX_W-1:0];
          src_nxt     = gap_p1;
          state_nxt   = S_SHDN;
        end
      end

      S_SHDN: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = src_m1[IDX_W-1:0];
        if (src_r == cnt_m1) begin
          cnt_nxt    = cnt_m1;
          res_ok_nxt = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          ram_rd_addr = src_p1[IDX_W-1:0];
          src_nxt     = src_p1;
        end
      end

      S_SWAPRD: begin
        ram_rd_addr = cnt_m1[IDX_W-1:0];
        state_nxt   = S_SWAPWR;
      end

      S_SWAPWR: begin
        // last entry fills the hole; harmless when the hole is the last entry
        ram_wr_en  = 1'b1;
        cnt_nxt    = cnt_m1;
        res_ok_nxt = 1'b1;
        state_nxt  = S_DONE;
      end

      S_FETCH: begin
        res_ok_nxt  = 1'b1;
        res_key_nxt = rd_ent.key;
        res_pay_nxt = rd_ent.payload;
        state_nxt   = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    pay_r     <= pay_nxt;
    gap_r     <= gap_nxt;
    src_r     <= src_nxt;
    res_ok_r  <= res_ok_nxt;
    res_key_r <= res_key_nxt;
    res_pay_r <= res_pay_nxt;
    if (out_load) begin
      out_ok_r    <= res_ok_r;
      out_key_r   <= res_key_r;
      out_pay_r   <= res_pay_r;
      out_cnt_r   <= cnt_r;
      out_full_r  <= is_full;
      out_empty_r <= is_empty;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;

  always_comb begin
    out_tdata = '0;
    out_tdata[bale_pkg::OUT_KEY_LO +: KEY_W] = out_key_r;
    out_tdata[bale_pkg::OUT_PAY_LO +: PAY_W] = out_pay_r;
    out_tdata[bale_pkg::OUT_CNT_LO +: CNT_W] = out_cnt_r;
    out_tdata[bale_pkg::OUT_FULL_BIT]        = out_full_r;
    out_tdata[bale_pkg::OUT_EMPTY_BIT]       = out_empty_r;
  end

endmodule

/* design/bale_checker.sv */
`include "bounded_array_list_engine_defines.svh"

module bale_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bale_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  logic [bale_pkg::CNT_W-1:0] seen_cnt;
  logic                       seen_full;
  logic                       seen_empty;

  assign seen_cnt   = out_tdata[bale_pkg::OUT_CNT_LO +: bale_pkg::CNT_W];
  assign seen_full  = out_tdata[bale_pkg::OUT_FULL_BIT];
  assign seen_empty = out_tdata[bale_pkg::OUT_EMPTY_BIT];

  // stalled result holds
  `BALE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // flags agree with the count
  `BALE_ASSERT_NOW(a_flags, clk, rst_n, out_tvalid, (seen_full == (seen_cnt == bale_pkg::CNT_W'(bale_pkg::CAPACITY))) && (seen_empty == (seen_cnt == '0)), "full or empty flag disagrees with count")

  // a failed request carries no record
  `BALE_ASSERT_NOW(a_fail_zero, clk, rst_n, out_tvalid && !out_tuser, out_tdata[bale_pkg::OUT_CNT_LO-1:0] == '0, "failed request returned record data")

  // one request at a time
  `BALE_ASSERT_NEXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready, "request taken while busy")

endmodule

bind bounded_array_list_engine bale_checker u_bale_checker (.*);
